// ----- rtl/core/mqtt_fixed_header_deframer_macros.svh -----
// Assertion macros used by the deframer top-level RTL.
`ifndef MQTT_FIXED_HEADER_DEFRAMER_MACROS_SVH
`define MQTT_FIXED_HEADER_DEFRAMER_MACROS_SVH

`ifndef NO_ASSERTIONS

`define MFHD_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

`define MFHD_ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`else

`define MFHD_ASSERT(lbl, clk, rst_n, prop, msg)

`define MFHD_ASSERT_NEVER(lbl, clk, rst_n, cond, msg)

`endif

`endif

// ----- rtl/core/mfhd_pkg.sv -----
package mfhd_pkg;

  localparam int unsigned LenW = 28;
  localparam int unsigned CntW = 3;
  localparam int unsigned MaxLengthBytes = 4;

  localparam logic [1:0] PhHeader  = 2'd0;
  localparam logic [1:0] PhLength  = 2'd1;
  localparam logic [1:0] PhPayload = 2'd2;

  localparam logic [1:0] KindHeader  = 2'd0;
  localparam logic [1:0] KindLength  = 2'd1;
  localparam logic [1:0] KindPayload = 2'd2;

  typedef struct packed {
    logic [7:0]      data_byte;
    logic [1:0]      field_kind;
    logic            frame_start;
    logic            frame_end;
    logic            length_done;
    logic [LenW-1:0] remaining_length;
    logic            length_error;
  } result_t;

  typedef struct packed {
    logic [1:0] phase;
    logic       left_zero;
  } parse_status_t;

endpackage

// ----- rtl/core/mfhd_in_reg.sv -----
module mfhd_in_reg (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] in_byte_i,
  input  logic       pop_i,
  output logic       valid_o,
  output logic [7:0] byte_o
);

  logic       valid_q;
  logic [7:0] byte_q;

  assign in_ready_o = !valid_q || pop_i;
  assign valid_o    = valid_q;
  assign byte_o     = byte_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      byte_q <= in_byte_i;
    end
  end

endmodule

// ----- rtl/core/mfhd_parser.sv -----
module mfhd_parser (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   step_i,
  input  logic [7:0]             byte_i,
  output mfhd_pkg::result_t      result_o,
  output mfhd_pkg::parse_status_t status_o
);

  logic [1:0]                  phase_q, phase_d;
  logic [mfhd_pkg::LenW-1:0]   acc_q, acc_d;
  logic [mfhd_pkg::CntW-1:0]   cnt_q, cnt_d;
  logic [mfhd_pkg::LenW-1:0]   left_q, left_d;
  logic [mfhd_pkg::LenW-1:0]   group;
  logic [mfhd_pkg::LenW-1:0]   sum;
  logic [mfhd_pkg::CntW-1:0]   cnt_next;

  always_comb begin
    case (cnt_q[1:0])
      2'd0:    group = {21'd0, byte_i[6:0]};
      2'd1:    group = {14'd0, byte_i[6:0], 7'd0};
      2'd2:    group = {7'd0, byte_i[6:0], 14'd0};
      default: group = {byte_i[6:0], 21'd0};
    endcase
  end

  assign sum      = acc_q + group;
  assign cnt_next = cnt_q + 3'd1;

  always_comb begin
    phase_d  = phase_q;
    acc_d    = acc_q;
    cnt_d    = cnt_q;
    left_d   = left_q;
    result_o = '0;
    result_o.data_byte = byte_i;
    unique case (phase_q)
      mfhd_pkg::PhLength: begin
        result_o.field_kind = mfhd_pkg::KindLength;
        if (!byte_i[7]) begin
          result_o.length_done      = 1'b1;
          result_o.remaining_length = sum;
          if (sum == '0) begin
            result_o.frame_end = 1'b1;
            phase_d = mfhd_pkg::PhHeader;
          end else begin
            left_d  = sum;
            phase_d = mfhd_pkg::PhPayload;
          end
          acc_d = '0;
          cnt_d = '0;
        end else if (cnt_next >= mfhd_pkg::CntW'(mfhd_pkg::MaxLengthBytes)) begin
          result_o.length_error = 1'b1;
          phase_d = mfhd_pkg::PhHeader;
          acc_d   = '0;
          cnt_d   = '0;
          left_d  = '0;
        end else begin
          acc_d = sum;
          cnt_d = cnt_next;
        end
      end
      mfhd_pkg::PhPayload: begin
        result_o.field_kind = mfhd_pkg::KindPayload;
        if (left_q <= mfhd_pkg::LenW'(1)) begin
          left_d             = '0;
          result_o.frame_end = 1'b1;
          phase_d            = mfhd_pkg::PhHeader;
        end else begin
          left_d = left_q - mfhd_pkg::LenW'(1);
        end
      end
      default: begin
        result_o.field_kind  = mfhd_pkg::KindHeader;
        result_o.frame_start = 1'b1;
        phase_d = mfhd_pkg::PhLength;
        acc_d   = '0;
        cnt_d   = '0;
        left_d  = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= mfhd_pkg::PhHeader;
      acc_q   <= '0;
      cnt_q   <= '0;
      left_q  <= '0;
    end else if (step_i) begin
      phase_q <= phase_d;
      acc_q   <= acc_d;
      cnt_q   <= cnt_d;
      left_q  <= left_d;
    end
  end

  assign status_o.phase     = phase_q;
  assign status_o.left_zero = (left_q == '0);

endmodule

// ----- rtl/core/mfhd_out_reg.sv -----
module mfhd_out_reg (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              load_i,
  input  mfhd_pkg::result_t result_i,
  output logic              can_load_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output mfhd_pkg::result_t result_o
);

  logic              valid_q;
  mfhd_pkg::result_t result_q;

  assign can_load_o  = !valid_q || out_ready_i;
  assign out_valid_o = valid_q;
  assign result_o    = result_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (can_load_o) begin
      valid_q <= load_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (can_load_o && load_i) begin
      result_q <= result_i;
    end
  end

endmodule

// ----- rtl/core/mqtt_fixed_header_deframer.sv -----
// MQTT fixed-header deframer.
// The slave stream takes one raw byte per item on s_axis_tdata_i. The master
// stream gives one tagged item per input byte: the byte itself, the field it
// belongs to, frame start and end marks, and the decoded remaining length on
// the byte that completes the length field. Length fields longer than four
// bytes raise length_error and the parser waits for a new header byte.
// An accepted byte is held in an input register; the parse step runs in the
// cycle it leaves that register and its result is written into the output
// register, from which it is offered on the master stream.
// One item is accepted every cycle while the receiver keeps m_axis_tready_i
// high; the parse state update is a single add, compare and decrement.
// When the receiver stalls, the output register holds its item and the input
// register takes one more byte before s_axis_tready_o falls.
// Reset empties both registers and leaves the parser waiting for a header.
`include "mqtt_fixed_header_deframer_macros.svh"

module mqtt_fixed_header_deframer (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [7:0] byte_value
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [39:0] m_axis_tdata_o,   // [7:0] data_byte, [35:8] remaining_length, rest zero
  output logic [4:0]  m_axis_tuser_o,   // [1:0] field_kind, [2] frame_start, [3] length_done,
                                        // [4] length_error
  output logic        m_axis_tlast_o    // frame_end
);

  logic                    in_valid;
  logic [7:0]              in_byte;
  logic                    can_load;
  logic                    step;
  mfhd_pkg::result_t       step_result;
  mfhd_pkg::result_t       out_result;
  mfhd_pkg::parse_status_t status;

  assign step = in_valid && can_load;

  mfhd_in_reg u_in_reg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .in_byte_i  (s_axis_tdata_i),
    .pop_i      (step),
    .valid_o    (in_valid),
    .byte_o     (in_byte)
  );

  mfhd_parser u_parser (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (step),
    .byte_i   (in_byte),
    .result_o (step_result),
    .status_o (status)
  );

  mfhd_out_reg u_out_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (step),
    .result_i    (step_result),
    .can_load_o  (can_load),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .result_o    (out_result)
  );

  assign m_axis_tdata_o = {4'd0, out_result.remaining_length, out_result.data_byte};
  assign m_axis_tuser_o = {out_result.length_error, out_result.length_done,
                           out_result.frame_start, out_result.field_kind};
  assign m_axis_tlast_o = out_result.frame_end;

  `MFHD_ASSERT(a_payload_count_live, clk_i, rst_ni,
    (status.phase == mfhd_pkg::PhPayload) |-> !status.left_zero,
    "Payload phase with zero bytes left.")
  `MFHD_ASSERT(a_error_only_on_length, clk_i, rst_ni,
    (m_axis_tvalid_o && out_result.length_error) |->
      (out_result.field_kind == mfhd_pkg::KindLength && !out_result.length_done &&
       !m_axis_tlast_o),
    "Length error on a byte that is not an open length byte.")
  `MFHD_ASSERT(a_start_is_header, clk_i, rst_ni,
    (m_axis_tvalid_o && out_result.frame_start) |->
      (out_result.field_kind == mfhd_pkg::KindHeader && !m_axis_tlast_o),
    "Frame start on a byte that is not a header byte.")
  `MFHD_ASSERT(a_zero_length_ends, clk_i, rst_ni,
    (m_axis_tvalid_o && out_result.length_done && out_result.remaining_length == '0) |->
      m_axis_tlast_o,
    "Zero remaining length without frame end.")

endmodule

// ----- bench/mqtt_fixed_header_deframer_tb.sv -----
module mqtt_fixed_header_deframer_tb;

  localparam int unsigned QuietLimit = 2000;
  localparam int unsigned PhaseItems = 140;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid_i;
  logic        s_axis_tready_o;
  logic [7:0]  s_axis_tdata_i;
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i;
  logic [39:0] m_axis_tdata_o;
  logic [4:0]  m_axis_tuser_o;
  logic        m_axis_tlast_o;

  int unsigned idle_pct;
  int unsigned stall_pct;
  int unsigned bytes_sent;
  int unsigned quiet_cycles = 0;

  class deframe_scoreboard;
    logic [1:0]                phase;
    logic [mfhd_pkg::LenW-1:0] len_acc;
    logic [mfhd_pkg::CntW-1:0] len_cnt;
    logic [mfhd_pkg::LenW-1:0] payload_left;
    mfhd_pkg::result_t         pending_tags[$];
    int unsigned               errors;

    function new();
      phase        = mfhd_pkg::PhHeader;
      len_acc      = '0;
      len_cnt      = '0;
      payload_left = '0;
      errors       = 0;
    endfunction

    function void note_byte(logic [7:0] value);
      mfhd_pkg::result_t         tag;
      logic [mfhd_pkg::LenW-1:0] group;
      tag           = '0;
      tag.data_byte = value;
      case (phase)
        mfhd_pkg::PhLength: begin
          tag.field_kind = mfhd_pkg::KindLength;
          group   = {{(mfhd_pkg::LenW-7){1'b0}}, value[6:0]} << (7 * len_cnt[1:0]);
          len_acc = len_acc + group;
          len_cnt = len_cnt + 1'b1;
          if (!value[7]) begin
            tag.length_done      = 1'b1;
            tag.remaining_length = len_acc;
            if (len_acc == '0) begin
              tag.frame_end = 1'b1;
              phase         = mfhd_pkg::PhHeader;
            end else begin
              payload_left = len_acc;
              phase        = mfhd_pkg::PhPayload;
            end
            len_acc = '0;
            len_cnt = '0;
          end else if (len_cnt >= mfhd_pkg::MaxLengthBytes) begin
            tag.length_error = 1'b1;
            phase            = mfhd_pkg::PhHeader;
            len_acc          = '0;
            len_cnt          = '0;
            payload_left     = '0;
          end
        end
        mfhd_pkg::PhPayload: begin
          tag.field_kind = mfhd_pkg::KindPayload;
          if (payload_left <= 1) begin
            payload_left  = '0;
            tag.frame_end = 1'b1;
            phase         = mfhd_pkg::PhHeader;
          end else begin
            payload_left = payload_left - 1'b1;
          end
        end
        default: begin
          tag.field_kind  = mfhd_pkg::KindHeader;
          tag.frame_start = 1'b1;
          phase           = mfhd_pkg::PhLength;
          len_acc         = '0;
          len_cnt         = '0;
          payload_left    = '0;
        end
      endcase
      pending_tags.push_back(tag);
    endfunction

    function void compare(string name, logic [mfhd_pkg::LenW-1:0] want,
                          logic [mfhd_pkg::LenW-1:0] seen);
      if (seen !== want) begin
        $error("%s: expected 0x%0h, got 0x%0h", name, want, seen);
        errors++;
      end
    endfunction

    function void check_tag(mfhd_pkg::result_t seen);
      mfhd_pkg::result_t want;
      if (pending_tags.size() == 0) begin
        $error("item on the master side with no byte waiting for it");
        errors++;
        return;
      end
      want = pending_tags.pop_front();
      compare("data_byte", mfhd_pkg::LenW'(want.data_byte), mfhd_pkg::LenW'(seen.data_byte));
      compare("field_kind", mfhd_pkg::LenW'(want.field_kind),
              mfhd_pkg::LenW'(seen.field_kind));
      compare("frame_start", mfhd_pkg::LenW'(want.frame_start),
              mfhd_pkg::LenW'(seen.frame_start));
      compare("frame_end", mfhd_pkg::LenW'(want.frame_end), mfhd_pkg::LenW'(seen.frame_end));
      compare("length_done", mfhd_pkg::LenW'(want.length_done),
              mfhd_pkg::LenW'(seen.length_done));
      compare("remaining_length", want.remaining_length, seen.remaining_length);
      compare("length_error", mfhd_pkg::LenW'(want.length_error),
              mfhd_pkg::LenW'(seen.length_error));
    endfunction
  endclass

  deframe_scoreboard tracker = new();

  mqtt_fixed_header_deframer i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o),
    .m_axis_tlast_o  (m_axis_tlast_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    mfhd_pkg::result_t seen;
    if (rst_ni) begin
      if (s_axis_tvalid_i && s_axis_tready_o) begin
        tracker.note_byte(s_axis_tdata_i);
      end
      if (m_axis_tvalid_o && m_axis_tready_i) begin
        seen                  = '0;
        seen.data_byte        = m_axis_tdata_o[7:0];
        seen.remaining_length = m_axis_tdata_o[35:8];
        seen.field_kind       = m_axis_tuser_o[1:0];
        seen.frame_start      = m_axis_tuser_o[2];
        seen.length_done      = m_axis_tuser_o[3];
        seen.length_error     = m_axis_tuser_o[4];
        seen.frame_end        = m_axis_tlast_o;
        tracker.check_tag(seen);
      end
      if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
    end
  end

  initial begin
    m_axis_tready_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      m_axis_tready_i = ($urandom_range(99) >= stall_pct);
    end
  end

  initial begin
    while (quiet_cycles < QuietLimit) @(posedge clk_i);
    $display("== FAIL ==");
    $finish;
  end

  task automatic push_byte(input logic [7:0] value);
    while ($urandom_range(99) < idle_pct) begin
      s_axis_tvalid_i = 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid_i = 1'b1;
    s_axis_tdata_i  = value;
    do @(posedge clk_i); while (!s_axis_tready_o);
    @(negedge clk_i);
    bytes_sent++;
  endtask

  task automatic drain();
    s_axis_tvalid_i = 1'b0;
    while (tracker.pending_tags.size() != 0) @(negedge clk_i);
  endtask

  // Frame lengths stay small so that the parser keeps returning to the header state.
  task automatic push_random_frame();
    int unsigned pick;
    int unsigned low;
    int unsigned len;
    pick = $urandom_range(99);
    low  = $urandom_range(15);
    push_byte(8'($urandom));
    if (pick < 8) begin
      repeat (4) push_byte(8'h80 | 8'($urandom_range(127)));
      return;
    end
    if (pick < 58) begin
      len = $urandom_range(12);
      push_byte(8'(len));
    end else if (pick < 61) begin
      len = $urandom_range(127, 13);
      push_byte(8'(len));
    end else if (pick < 80) begin
      len = ($urandom_range(9) == 0) ? low + 128 : low;
      push_byte(8'h80 | 8'(low));
      push_byte(8'(len >> 7));
    end else if (pick < 90) begin
      len = low;
      push_byte(8'h80 | 8'(low));
      push_byte(8'h80);
      push_byte(8'h00);
    end else begin
      len = low;
      push_byte(8'h80 | 8'(low));
      push_byte(8'h80);
      push_byte(8'h80);
      push_byte(8'h00);
    end
    repeat (len) push_byte(8'($urandom));
  endtask

  initial begin
    logic [7:0]  directed_bytes [23];
    int unsigned idle_plan  [4];
    int unsigned stall_plan [4];
    int unsigned target;

    directed_bytes = '{
      8'h00, 8'h00,
      8'hFF, 8'h01, 8'hFF,
      8'h30, 8'h02, 8'h00, 8'hA5,
      8'h82, 8'h80, 8'h00,
      8'h10, 8'h81, 8'h80, 8'h80, 8'h00, 8'h5A,
      8'hE0, 8'hFF, 8'hFF, 8'hFF, 8'h80
    };
    idle_plan  = '{0, 69, 0, 34};
    stall_plan = '{0, 0, 69, 34};

    rst_ni          = 1'b0;
    s_axis_tvalid_i = 1'b0;
    s_axis_tdata_i  = '0;
    idle_pct        = 0;
    stall_pct       = 0;
    bytes_sent      = 0;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    foreach (directed_bytes[i]) push_byte(directed_bytes[i]);
    drain();

    for (int p = 0; p < 4; p++) begin
      idle_pct  = idle_plan[p];
      stall_pct = stall_plan[p];
      target    = bytes_sent + PhaseItems;
      while (bytes_sent < target) push_random_frame();
      drain();
    end

    // The largest length leaves the parser deep in a payload, so it comes last.
    idle_pct  = 34;
    stall_pct = 34;
    push_byte(8'h30);
    push_byte(8'hFF);
    push_byte(8'hFF);
    push_byte(8'hFF);
    push_byte(8'h7F);
    repeat (3) push_byte(8'($urandom));
    drain();
    repeat (8) @(negedge clk_i);

    if (tracker.errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
